### src/cvh_pkg.sv
// Shared types and constants for the convex hull unit.
package cvh_pkg;

  // Controller-to-datapath command group
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PIV_INIT,
    OP_PIV_STEP,
    OP_SORT_RD,
    OP_SORT_CMP,
    OP_SORT_WR,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_OUT_RD
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] idx;
    logic [6:0] aux;
  } cmd_t;

  typedef struct packed {
    logic less;   // sort: candidate precedes element
    logic keep;   // scan: strict left turn
  } sts_t;

endpackage

### src/cvh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cvh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/cvh_dp.sv
// Datapath: point store, order and stack memories, cross-product compare.
module cvh_dp #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic                       clk,
  input  cvh_pkg::cmd_t              cmd,
  input  logic [2*COORD_WIDTH-1:0]   in_pt,
  output cvh_pkg::sts_t              sts,
  output logic [2*COORD_WIDTH-1:0]   out_pt
);
  import cvh_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  typedef logic signed [CW-1:0] crd_t;

  // point store: two read ports via two RAM copies, plus an index RAM pair
  logic           ps_we;
  logic [AW-1:0]  ps_wa, ps_ra0, ps_ra1;
  logic [2*CW-1:0] ps_wd, ps_rd0, ps_rd1;
  logic           so_we;
  logic [AW-1:0]  so_wa, so_ra;
  logic [AW-1:0]  so_wd, so_rd;
  logic           hs_we;
  logic [AW-1:0]  hs_wa, hs_ra;
  logic [AW-1:0]  hs_wd, hs_rd;

  cvh_ram #(.WIDTH(2*CW), .DEPTH(MAX_POINTS)) u_ps0 (
    .clk, .we(ps_we), .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra0), .rdata(ps_rd0));
  cvh_ram #(.WIDTH(2*CW), .DEPTH(MAX_POINTS)) u_ps1 (
    .clk, .we(ps_we), .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra1), .rdata(ps_rd1));
  cvh_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_so (
    .clk, .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_rd));
  cvh_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_hs (
    .clk, .we(hs_we), .waddr(hs_wa), .wdata(hs_wd), .raddr(hs_ra), .rdata(hs_rd));

  // Sequencing (controller drives one op per cycle, OP_NONE while it waits):
  //  PIV_INIT idx=0: read point 0 -> next cycle latch as pivot.
  //  PIV_STEP idx=i: read point i; compared the cycle after.
  //  SORT_RD idx=i aux=j: read so[j-1] and point i.
  //  SORT_CMP: port1 reads point so[j-1]; cross stage.
  //  SORT_WR: write so[aux]=candidate index, or with idx[6] shift so[aux]=so[aux-1].
  //  SCAN_*: read hs top two and sorted point.
  crd_t           pvx_r, pvy_r;
  logic [2*CW-1:0] cand_r;
  logic [AW-1:0]  elem_r;
  logic [AW-1:0]  cidx_r;
  op_t            op_d1_r, op_d2_r, op_d3_r;
  logic [6:0]     idx_d1_r;
  logic signed [PW-1:0] l_r, r_r;
  logic [PW:0]    da_r, db_r;
  logic           less_r, keep_r;
  logic [2*CW-1:0] ua_r, ta_r;

  // operand registers feeding the multipliers
  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [PW-1:0] sq_ax, sq_ay, sq_bx, sq_by;

  // stack depth is tracked by controller; scan needs hs[d-1], hs[d-2]
  logic [AW-1:0]  hs_t_r;

  always_comb begin
    ps_we  = (cmd.op == OP_LOAD);
    ps_wa  = cmd.idx[AW-1:0];
    ps_wd  = in_pt;
    ps_ra0 = cmd.idx[AW-1:0];
    ps_ra1 = so_rd;
    so_we  = 1'b0;
    so_wa  = cmd.aux[AW-1:0];
    so_wd  = cidx_r;
    so_ra  = cmd.aux[AW-1:0] - AW'(1);
    hs_we  = 1'b0;
    hs_wa  = cmd.aux[AW-1:0];
    hs_wd  = cmd.idx[AW-1:0];
    hs_ra  = cmd.aux[AW-1:0] - AW'(1);
    case (cmd.op)
      OP_SORT_RD: begin
        so_ra = cmd.aux[AW-1:0] - AW'(1);
      end
      OP_SORT_WR: begin
        so_we = 1'b1;
        so_wd = cmd.idx[6] ? elem_r : cidx_r;
      end
      OP_SCAN_RD: begin
        so_ra  = cmd.aux[AW-1:0] == cmd.aux[AW-1:0] ? cmd.idx[AW-1:0] : cmd.idx[AW-1:0];
        hs_ra  = cmd.aux[AW-1:0] - AW'(1);
      end
      OP_SCAN_CMP: begin
        // idx[6] set: push so value at depth aux
        hs_we = cmd.idx[6];
        hs_wd = elem_r;
        hs_ra = cmd.aux[AW-1:0] - AW'(2);
        ps_ra0 = hs_rd;
      end
      OP_OUT_RD: begin
        hs_ra  = cmd.idx[AW-1:0];
      end
      default: ;
    endcase
    // second stack entry of a turn test, or the vertex to output, via port 0
    if ((op_d1_r == OP_SCAN_CMP && !idx_d1_r[6]) || op_d1_r == OP_OUT_RD) begin
      ps_ra0 = hs_rd;
    end
  end

  function automatic logic signed [DW-1:0] dif(logic [CW-1:0] a, logic [CW-1:0] b);
    return DW'($signed(a)) - DW'($signed(b));
  endfunction

  always_ff @(posedge clk) begin
    op_d1_r  <= cmd.op;
    idx_d1_r <= cmd.idx;
    op_d2_r  <= op_d1_r;
    op_d3_r  <= op_d2_r;
    if (cmd.op == OP_SORT_RD) begin
      cidx_r <= cmd.idx[AW-1:0];
    end
    if (op_d1_r == OP_SORT_RD) begin
      elem_r <= so_rd;
      cand_r <= ps_rd0;
    end
    if (op_d1_r == OP_SCAN_RD) begin
      elem_r <= so_rd;
      hs_t_r <= hs_rd;
    end
    if (op_d1_r == OP_SCAN_CMP) begin
      ta_r <= ps_rd0;
      cand_r <= ps_rd1;
    end
    if (op_d1_r == OP_PIV_INIT) begin
      pvx_r <= crd_t'(ps_rd0[CW-1:0]);
      pvy_r <= crd_t'(ps_rd0[2*CW-1:CW]);
    end
    if (op_d1_r == OP_PIV_STEP) begin
      if ($signed(ps_rd0[2*CW-1:CW]) < pvy_r ||
          ($signed(ps_rd0[2*CW-1:CW]) == pvy_r && $signed(ps_rd0[CW-1:0]) < pvx_r)) begin
        pvx_r <= crd_t'(ps_rd0[CW-1:0]);
        pvy_r <= crd_t'(ps_rd0[2*CW-1:CW]);
      end
    end
    if (op_d1_r == OP_OUT_RD) begin
      elem_r <= hs_rd;
    end
  end

  assign sq_ax = ax_r * ax_r;
  assign sq_ay = ay_r * ay_r;
  assign sq_bx = bx_r * bx_r;
  assign sq_by = by_r * by_r;

  // second phase: operands
  // SORT: ps_rd1 = point so[j-1], read at the address so_rd gives during cmd SORT_CMP
  // SCAN: after SCAN_CMP, ps_rd1 = point of elem (so_rd), ps_rd0 = point of stack top hs[d-1]
  logic sel_ps0_t;
  assign sel_ps0_t = 1'b0;
  always_ff @(posedge clk) begin
    if (op_d1_r == OP_SORT_CMP) begin
      ax_r <= dif(cand_r[CW-1:0], pvx_r);
      ay_r <= dif(cand_r[2*CW-1:CW], pvy_r);
      bx_r <= dif(ps_rd1[CW-1:0], pvx_r);
      by_r <= dif(ps_rd1[2*CW-1:CW], pvy_r);
    end
    if (op_d2_r == OP_SCAN_CMP) begin
      ua_r <= ps_rd0;
    end
    if (op_d3_r == OP_SCAN_CMP) begin
      ax_r <= dif(ta_r[CW-1:0], ua_r[CW-1:0]);
      ay_r <= dif(ta_r[2*CW-1:CW], ua_r[2*CW-1:CW]);
      bx_r <= dif(cand_r[CW-1:0], ua_r[CW-1:0]);
      by_r <= dif(cand_r[2*CW-1:CW], ua_r[2*CW-1:CW]);
    end
    l_r  <= ax_r * by_r;
    r_r  <= ay_r * bx_r;
    // squares are never negative
    da_r <= {1'b0, sq_ax} + {1'b0, sq_ay};
    db_r <= {1'b0, sq_bx} + {1'b0, sq_by};
    less_r <= (l_r > r_r) || (l_r == r_r && da_r < db_r);
    keep_r <= (l_r > r_r);
  end

  assign sts.less = less_r;
  assign sts.keep = keep_r;
  assign out_pt   = ps_rd0;

  logic unused;
  assign unused = sel_ps0_t ^ idx_d1_r[0] ^ hs_t_r[0];

endmodule

### src/cvh_ctrl.sv
// Controller: load, pivot search, insertion sort, stack scan, output.
module cvh_ctrl #(
  parameter int MAX_POINTS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          in_last,
  output logic          in_rdy,
  input  cvh_pkg::sts_t sts,
  output cvh_pkg::cmd_t cmd,
  output logic          out_vld,
  output logic          out_lst,
  output logic          out_ovf,
  input  logic          out_rdy,
  output logic          out_cap
);
  import cvh_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_PIV, S_PIVW, S_SRD, S_SCMP, S_SWAIT, S_SWR,
    S_KRD, S_KCMP, S_KWAIT, S_KPUSH, S_ORD, S_OWAIT, S_OUT
  } st_t;

  st_t        st_r, st_nxt;
  logic [6:0] n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, d_r, d_nxt, k_r, k_nxt;
  logic [2:0] w_r, w_nxt;
  logic       ovf_r, ovf_nxt, lst_r, lst_nxt;

  always_comb begin
    st_nxt = st_r; n_nxt = n_r; i_nxt = i_r; j_nxt = j_r; d_nxt = d_r;
    k_nxt = k_r; w_nxt = w_r; ovf_nxt = ovf_r; lst_nxt = lst_r;
    cmd = '{op: OP_NONE, idx: 7'd0, aux: 7'd0};
    in_rdy = 1'b0;
    out_vld = 1'b0;
    out_cap = 1'b0;
    case (st_r)
      S_LOAD: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          if (n_r < 7'(MAX_POINTS)) begin
            cmd = '{op: OP_LOAD, idx: n_r, aux: 7'd0};
            n_nxt = n_r + 7'd1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            st_nxt = S_PIV;
            i_nxt = 7'd0;
          end
        end
      end
      S_PIV: begin
        cmd = '{op: (i_r == 7'd0) ? OP_PIV_INIT : OP_PIV_STEP, idx: i_r, aux: 7'd0};
        i_nxt = i_r + 7'd1;
        if (i_r + 7'd1 == n_r) st_nxt = S_PIVW;
      end
      S_PIVW: begin
        st_nxt = S_SRD; i_nxt = 7'd0; j_nxt = 7'd0;
      end
      S_SRD: begin
        if (i_r == n_r) begin
          st_nxt = S_KRD; i_nxt = 7'd0; d_nxt = 7'd0;
        end else begin
          cmd = '{op: OP_SORT_RD, idx: i_r, aux: j_r};
          st_nxt = (j_r == 7'd0) ? S_SWR : S_SCMP;
        end
      end
      S_SCMP: begin
        cmd = '{op: OP_SORT_CMP, idx: i_r, aux: j_r};
        st_nxt = S_SWAIT; w_nxt = 3'd0;
      end
      S_SWAIT: begin
        w_nxt = w_r + 3'd1;
        if (w_r == 3'd3) begin
          if (sts.less) begin
            cmd = '{op: OP_SORT_WR, idx: 7'h40, aux: j_r};
            j_nxt = j_r - 7'd1;
            st_nxt = S_SRD;
            // re-read with new j; SORT_RD reloads candidate point, harmless
          end else begin
            st_nxt = S_SWR;
          end
        end
      end
      S_SWR: begin
        cmd = '{op: OP_SORT_WR, idx: 7'd0, aux: j_r};
        i_nxt = i_r + 7'd1; j_nxt = i_r + 7'd1;
        st_nxt = S_SRD;
      end
      S_KRD: begin
        if (i_r == n_r) begin
          st_nxt = S_ORD; k_nxt = 7'd0;
        end else begin
          cmd = '{op: OP_SCAN_RD, idx: i_r, aux: d_r};
          st_nxt = S_KCMP;
        end
      end
      S_KCMP: begin
        if (d_r > 7'd1) begin
          cmd = '{op: OP_SCAN_CMP, idx: 7'd0, aux: d_r};
          st_nxt = S_KWAIT; w_nxt = 3'd0;
        end else begin
          st_nxt = S_KPUSH;
        end
      end
      S_KWAIT: begin
        // two point reads, operand stage, multiply, compare
        w_nxt = w_r + 3'd1;
        if (w_r == 3'd5) begin
          if (sts.keep) begin
            st_nxt = S_KPUSH;
          end else begin
            d_nxt = d_r - 7'd1;
            st_nxt = S_KRD;
          end
        end
      end
      S_KPUSH: begin
        cmd = '{op: OP_SCAN_CMP, idx: 7'h40, aux: d_r};
        d_nxt = d_r + 7'd1; i_nxt = i_r + 7'd1;
        st_nxt = S_KRD;
      end
      S_ORD: begin
        cmd = '{op: OP_OUT_RD, idx: k_r, aux: 7'd0};
        st_nxt = S_OWAIT; w_nxt = 3'd0;
      end
      S_OWAIT: begin
        // hs read then point read via port 0
        w_nxt = w_r + 3'd1;
        if (w_r == 3'd1) begin
          out_cap = 1'b1;
          lst_nxt = (k_r + 7'd1 == d_r);
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_vld = 1'b1;
        if (out_rdy) begin
          if (lst_r) begin
            st_nxt = S_LOAD; n_nxt = 7'd0; ovf_nxt = 1'b0;
          end else begin
            k_nxt = k_r + 7'd1; st_nxt = S_ORD;
          end
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; n_r <= 7'd0; ovf_r <= 1'b0; i_r <= 7'd0; j_r <= 7'd0;
      d_r <= 7'd0; k_r <= 7'd0; w_r <= 3'd0; lst_r <= 1'b0;
    end else begin
      st_r <= st_nxt; n_r <= n_nxt; ovf_r <= ovf_nxt; i_r <= i_nxt; j_r <= j_nxt;
      d_r <= d_nxt; k_r <= k_nxt; w_r <= w_nxt; lst_r <= lst_nxt;
    end
  end

  assign out_lst = lst_r;
  assign out_ovf = ovf_r;

endmodule

### src/convex_hull_graham_scan_unit.sv
// Top level of the Graham scan convex hull unit.
// Usage: stream points on the in_ channel, one transfer per cycle, the last
// point of a set with in_tlast high. Up to MAX_POINTS points are stored;
// extra points are dropped and flag overflow on every hull vertex.
// After the last point the unit stops accepting input while it finds the
// pivot, insertion-sorts by angle (up to n*n/2 compares, bound by the compare
// pipeline of the datapath) and runs the stack scan. Hull vertices then leave
// on the out_ channel counterclockwise from the pivot, out_tlast on the last
// one, with out_tvalid low between vertices while the next one is read; the
// output holds while the receiver stalls.
// Synchronous active-low reset returns the unit to loading with an empty
// store; memory contents are not cleared and need no clearing.
module convex_hull_graham_scan_unit #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] in_tdata, // point_x, point_y
  input  logic in_tlast,                               // last_point
  output logic out_tvalid,
  input  logic out_tready,
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] out_tdata, // hull_x, hull_y
  output logic out_tlast,                               // hull_last
  output logic out_tuser                                // overflow
);
  import cvh_pkg::*;

  localparam int TW = ((2*COORD_WIDTH+7)/8)*8;

  cmd_t cmd;
  sts_t sts;
  logic in_fire, out_cap, o_vld, o_lst, o_ovf;
  logic [2*COORD_WIDTH-1:0] dp_pt, hold_r;

  assign in_fire = in_tvalid && in_tready;

  cvh_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk, .rst_n, .in_fire, .in_last(in_tlast), .in_rdy(in_tready), .sts, .cmd,
    .out_vld(o_vld), .out_lst(o_lst), .out_ovf(o_ovf), .out_rdy(out_tready),
    .out_cap);

  cvh_dp #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk, .cmd, .in_pt(in_tdata[2*COORD_WIDTH-1:0]), .sts, .out_pt(dp_pt));

  always_ff @(posedge clk) begin
    if (out_cap) hold_r <= dp_pt;
  end

  assign out_tvalid = o_vld;
  assign out_tlast  = o_lst;
  assign out_tuser  = o_ovf;
  assign out_tdata  = TW'(hold_r);

  logic unused;
  assign unused = ^in_tdata;

endmodule

### bench/tb_convex_hull_graham_scan_unit.sv
// Testbench for the Graham scan convex hull unit: directed table plus random point sets.
`timescale 1ns / 100ps

module tb_convex_hull_graham_scan_unit;

  localparam int MAXP = 64;
  localparam int CW = 16;
  localparam int DW = ((2*CW+7)/8)*8;
  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } point_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
    logic                 ovf;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DW-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  convex_hull_graham_scan_unit #(.MAX_POINTS(MAXP), .COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  longint px[MAXP];
  longint py[MAXP];
  int     pcount = 0;
  bit     dropped = 1'b0;
  vertex_t hull_q[$];
  point_t  stim_q[$];
  int errors = 0;
  bit stim_done = 1'b0;

  function automatic int sgn_cross(longint ax, longint ay, longint bx, longint by);
    longint l, r;
    l = ax * by;
    r = ay * bx;
    return (l > r) ? 1 : (l < r) ? -1 : 0;
  endfunction

  function automatic bit angle_less(longint cx, longint cy, int a, int b);
    longint ax, ay, bx, by;
    int s;
    ax = px[a] - cx; ay = py[a] - cy;
    bx = px[b] - cx; by = py[b] - cy;
    s = sgn_cross(ax, ay, bx, by);
    if (s != 0) return s > 0;
    return (ax*ax + ay*ay) < (bx*bx + by*by);
  endfunction

  task automatic predict_hull();
    int ord[MAXP];
    int stk[MAXP];
    int depth, piv, j, v;
    longint cx, cy;
    vertex_t vx;
    piv = 0;
    for (int i = 1; i < pcount; i++)
      if (py[i] < py[piv] || (py[i] == py[piv] && px[i] < px[piv])) piv = i;
    cx = px[piv]; cy = py[piv];
    for (int i = 0; i < pcount; i++) begin
      v = i;
      j = i;
      while (j > 0 && angle_less(cx, cy, v, ord[j-1])) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = v;
    end
    depth = 0;
    for (int i = 0; i < pcount; i++) begin
      while (depth > 1) begin
        if (sgn_cross(px[stk[depth-1]] - px[stk[depth-2]], py[stk[depth-1]] - py[stk[depth-2]],
                      px[ord[i]] - px[stk[depth-2]], py[ord[i]] - py[stk[depth-2]]) > 0) break;
        depth--;
      end
      stk[depth] = ord[i];
      depth++;
    end
    for (int k = 0; k < depth; k++) begin
      vx.x = px[stk[k]][CW-1:0];
      vx.y = py[stk[k]][CW-1:0];
      vx.last = (k == depth - 1);
      vx.ovf = dropped;
      hull_q.push_back(vx);
    end
  endtask

  task automatic accept_point(point_t p);
    if (pcount < MAXP) begin
      px[pcount] = p.x;
      py[pcount] = p.y;
      pcount++;
    end else begin
      dropped = 1'b1;
    end
    if (p.last) begin
      predict_hull();
      pcount = 0;
      dropped = 1'b0;
    end
  endtask

  function automatic point_t mk(int x, int y, bit last);
    point_t p;
    p.x = x; p.y = y; p.last = last;
    return p;
  endfunction

  // directed rows; rows with a typed result are checked against it instead
  typedef struct {
    point_t  p;
    bit      has_exp;
    vertex_t e;
  } row_t;
  row_t dir_tab[$];
  vertex_t typed_q[$];

  function automatic void add_row(int x, int y, bit last);
    row_t r;
    r.p = mk(x, y, last);
    r.has_exp = 1'b0;
    dir_tab.push_back(r);
  endfunction

  function automatic void add_row_exp(int x, int y, bit last, int ex, int ey, bit el, bit eo);
    row_t r;
    r.p = mk(x, y, last);
    r.has_exp = 1'b1;
    r.e.x = ex; r.e.y = ey; r.e.last = el; r.e.ovf = eo;
    dir_tab.push_back(r);
  endfunction

  // random point set generation
  task automatic gen_set(int n, int span);
    int x, y;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin x = $urandom_range(0, 1) ? 32767 : -32768; y = $signed(16'($urandom)); end
        1: begin x = $signed(16'($urandom)); y = $urandom_range(0, 1) ? 32767 : -32768; end
        2: begin x = $urandom_range(0, 4) * 3; y = x * 2; end // collinear
        default: begin
          x = $urandom_range(0, 2*span) - span;
          y = $urandom_range(0, 2*span) - span;
        end
      endcase
      stim_q.push_back(mk(x, y, i == n - 1));
    end
  endtask

  // input driver
  initial begin
    point_t p;
    int gap;
    int total;
    add_row_exp(-32768, -32768, 1, -32768, -32768, 1, 0);   // single point
    add_row_exp(32767, 32767, 1, 32767, 32767, 1, 0);
    add_row(5, 5, 0); add_row(5, 5, 0); add_row(5, 5, 1);   // all equal
    add_row(0, 0, 0); add_row(2, 2, 0); add_row(1, 1, 0); add_row(3, 3, 1); // collinear
    add_row(0, 0, 0); add_row(10, 0, 0); add_row(10, 10, 0); add_row(0, 10, 0);
    add_row(5, 5, 0); add_row(10, 0, 0); add_row(5, 0, 1);  // square, dup, inner
    add_row(-32768, 32767, 0); add_row(32767, -32768, 0);
    add_row(-32768, -32768, 0); add_row(32767, 32767, 1);   // extremes
    add_row(-1, -1, 0); add_row(1, -1, 0); add_row(0, 1, 1);
    foreach (dir_tab[i]) begin
      stim_q.push_back(dir_tab[i].p);
      if (dir_tab[i].has_exp) typed_q.push_back(dir_tab[i].e);
    end
    // overflow set: 70 points, the last flagged
    gen_set(70, 30000);
    total = stim_q.size();
    while (total < 370) begin
      case ($urandom_range(0, 7))
        0: gen_set($urandom_range(1, 3), 20);
        1: gen_set($urandom_range(56, 64), 32767);
        default: gen_set($urandom_range(3, 16), $urandom_range(0, 1) ? 8 : 32767);
      endcase
      total = stim_q.size();
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
    while (stim_q.size() > 0) begin
      p = stim_q.pop_front();
      repeat (gap) @(posedge clk);
      in_tvalid <= 1'b1;
      in_tdata <= {p.y, p.x};
      in_tlast <= p.last;
      do @(posedge clk); while (!in_tready);
      accept_point(p);
      // valid stays high only when the next item follows at once
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
      if (stim_q.size() == 0 || gap != 0) in_tvalid <= 1'b0;
    end
    stim_done = 1'b1;
  end

  // output stall
  int stall = 0;
  always @(posedge clk) begin
    if (stall > 0) begin
      stall <= stall - 1;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      stall <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  vertex_t got, want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.x = out_tdata[CW-1:0];
      got.y = out_tdata[2*CW-1:CW];
      got.last = out_tlast;
      got.ovf = out_tuser;
      if (hull_q.size() == 0) begin
        $error("unexpected hull vertex x=%0d y=%0d", got.x, got.y);
        errors++;
      end else begin
        want = hull_q.pop_front();
        // typed single-point rows come first, one vertex each
        if (typed_q.size() > 0 && want.last) want = typed_q.pop_front();
        if (got.x != want.x) begin $error("hull_x exp %0d got %0d", want.x, got.x); errors++; end
        if (got.y != want.y) begin $error("hull_y exp %0d got %0d", want.y, got.y); errors++; end
        if (got.last != want.last) begin
          $error("hull_last exp %0d got %0d", want.last, got.last); errors++;
        end
        if (got.ovf != want.ovf) begin
          $error("overflow exp %0d got %0d", want.ovf, got.ovf); errors++;
        end
      end
    end
  end

  // watchdog and end of run
  int idle_cycles = 0;
  initial begin
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_convex_hull_graham_scan_unit failed");
        $finish;
      end
      if (stim_done && hull_q.size() == 0) begin
        repeat (50) @(posedge clk);
        if (errors == 0 && hull_q.size() == 0) begin
          $display("tb_convex_hull_graham_scan_unit passed");
        end else begin
          $display("tb_convex_hull_graham_scan_unit failed");
        end
        $finish;
      end
    end
  end

endmodule

### files.f
src/cvh_pkg.sv
src/cvh_ram.sv
src/cvh_dp.sv
src/cvh_ctrl.sv
src/convex_hull_graham_scan_unit.sv
bench/tb_convex_hull_graham_scan_unit.sv
